[rtl/fbqm_pkg.sv]
`default_nettype none

package fbqm_pkg;

    // raw command codes on the input word
    localparam logic [2:0] CODE_START       = 3'd0;
    localparam logic [2:0] CODE_ADD_BUFFER  = 3'd1;
    localparam logic [2:0] CODE_FRAME_START = 3'd2;
    localparam logic [2:0] CODE_FRAME_END   = 3'd3;
    localparam logic [2:0] CODE_DONE_TAKEN  = 3'd4;
    localparam logic [2:0] CODE_ABORT       = 3'd5;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_ADD_BUFFER,
        CMD_FRAME_START,
        CMD_FRAME_END,
        CMD_DONE_TAKEN,
        CMD_ABORT,
        CMD_BAD
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_WRONG_STATE = 2'd1,
        ST_NO_ROOM     = 2'd2,
        ST_DROPPED     = 2'd3
    } status_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] addr;
    } fbqm_cmd_t;

endpackage

`default_nettype wire

[rtl/fbqm_front.sv]
`default_nettype none

// Input side: classifies each word and holds up to two decoded commands.
module fbqm_front
    import fbqm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // buffer_addr
    input  wire logic [2:0]  s_tuser,   // command
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output fbqm_cmd_t        cmd_data
);

    fbqm_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;
    fbqm_cmd_t  decoded;

    always_comb begin
        decoded.addr = s_tdata;
        case (s_tuser)
            CODE_START:       decoded.kind = CMD_START;
            CODE_ADD_BUFFER:  decoded.kind = CMD_ADD_BUFFER;
            CODE_FRAME_START: decoded.kind = CMD_FRAME_START;
            CODE_FRAME_END:   decoded.kind = CMD_FRAME_END;
            CODE_DONE_TAKEN:  decoded.kind = CMD_DONE_TAKEN;
            CODE_ABORT:       decoded.kind = CMD_ABORT;
            default:          decoded.kind = CMD_BAD;
        endcase
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/fbqm_back.sv]
`default_nettype none

// Execution side: slots, pending FIFO, counters and the result register.
module fbqm_back
    import fbqm_pkg::*;
#(
    parameter int PENDING_DEPTH = 16,
    parameter int DONE_DEPTH    = 32
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire fbqm_cmd_t cmd_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output status_t    out_status,
    output logic       out_has_done,
    output logic [31:0] out_addr,
    output logic       out_ok,
    output logic [31:0] out_seq,
    output logic       out_last
);

    localparam int PAW  = $clog2(PENDING_DEPTH);
    localparam int PCW  = $clog2(PENDING_DEPTH + 1);
    localparam int OCW  = $clog2(DONE_DEPTH + 1);
    localparam int CMPW = $clog2(DONE_DEPTH + PENDING_DEPTH + 2) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AB_NEXT,
        S_AB_CUR,
        S_AB_PEND
    } state_t;

    state_t          state_reg, state_next;
    logic [PAW-1:0]  head_reg, head_next;
    logic [PAW-1:0]  tail_reg, tail_next;
    logic [PCW-1:0]  count_reg, count_next;
    logic [31:0]     next_addr_reg, next_addr_next;
    logic [31:0]     cur_addr_reg, cur_addr_next;
    logic [31:0]     frame_cnt_reg, frame_cnt_next;
    logic [OCW-1:0]  occ_reg, occ_next;
    logic            running_reg, running_next;

    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic            out_has_reg, out_has_next;
    logic [31:0]     out_addr_reg, out_addr_next;
    logic            out_ok_reg, out_ok_next;
    logic [31:0]     out_seq_reg, out_seq_next;
    logic            out_last_reg, out_last_next;

    logic [31:0]     pend_mem [PENDING_DEPTH];
    logic [31:0]     rd_data_reg;
    logic            wr_en;

    logic            can_emit;
    logic            done_full;
    logic            room_short;
    logic            fifo_full;
    logic            add_acc;
    logic            add_arm;
    logic            rep_last;
    logic [PAW-1:0]  head_inc;
    logic [PAW-1:0]  tail_inc;

    assign can_emit  = !out_valid_reg || out_ready;
    assign done_full = (occ_reg >= OCW'(DONE_DEPTH));
    assign room_short = (CMPW'(occ_reg) + CMPW'(count_reg) + CMPW'(1)) > CMPW'(DONE_DEPTH);
    assign fifo_full = (count_reg == PCW'(PENDING_DEPTH));
    assign add_acc   = running_reg && !room_short && !fifo_full;
    assign add_arm   = running_reg && (next_addr_reg == 32'd0) &&
                       ((count_reg != '0) || add_acc);
    assign head_inc  = (head_reg == PAW'(PENDING_DEPTH - 1)) ? '0 : head_reg + PAW'(1);
    assign tail_inc  = (tail_reg == PAW'(PENDING_DEPTH - 1)) ? '0 : tail_reg + PAW'(1);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        next_addr_next  = next_addr_reg;
        cur_addr_next   = cur_addr_reg;
        frame_cnt_next  = frame_cnt_reg;
        occ_next        = occ_reg;
        running_next    = running_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_has_next    = out_has_reg;
        out_addr_next   = out_addr_reg;
        out_ok_next     = out_ok_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        cmd_ready       = 1'b0;
        wr_en           = 1'b0;
        rep_last        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && can_emit) begin
                    cmd_ready       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_has_next    = 1'b0;
                    out_addr_next   = 32'd0;
                    out_ok_next     = 1'b0;
                    out_seq_next    = 32'd0;
                    out_last_next   = 1'b1;
                    case (cmd_data.kind)
                        CMD_START: begin
                            if (running_reg) begin
                                out_status_next = ST_WRONG_STATE;
                            end else begin
                                cur_addr_next  = 32'd0;
                                next_addr_next = 32'd0;
                                running_next   = 1'b1;
                            end
                        end
                        CMD_ADD_BUFFER: begin
                            if (!running_reg) begin
                                out_status_next = ST_WRONG_STATE;
                            end else if (!add_acc) begin
                                out_status_next = ST_NO_ROOM;
                            end
                            if (add_acc) begin
                                wr_en     = 1'b1;
                                tail_next = tail_inc;
                            end
                            if (add_arm) begin
                                head_next = head_inc;
                                // empty FIFO: the new word goes straight to the slot
                                next_addr_next = (count_reg == '0) ? cmd_data.addr
                                                                   : rd_data_reg;
                            end
                            if (add_acc && !add_arm) begin
                                count_next = count_reg + PCW'(1);
                            end else if (!add_acc && add_arm) begin
                                count_next = count_reg - PCW'(1);
                            end
                        end
                        CMD_FRAME_START: begin
                            if (!running_reg) begin
                                out_status_next = ST_WRONG_STATE;
                            end else begin
                                frame_cnt_next = frame_cnt_reg + 32'd1;
                                if (next_addr_reg != 32'd0) begin
                                    cur_addr_next = next_addr_reg;
                                end
                                if (count_reg != '0) begin
                                    next_addr_next = rd_data_reg;
                                    head_next      = head_inc;
                                    count_next     = count_reg - PCW'(1);
                                end else begin
                                    next_addr_next = 32'd0;
                                end
                            end
                        end
                        CMD_FRAME_END: begin
                            if (!running_reg) begin
                                out_status_next = ST_WRONG_STATE;
                            end else if (cur_addr_reg != 32'd0) begin
                                cur_addr_next = 32'd0;
                                out_addr_next = cur_addr_reg;
                                out_ok_next   = 1'b1;
                                out_seq_next  = frame_cnt_reg;
                                if (done_full) begin
                                    out_status_next = ST_DROPPED;
                                end else begin
                                    out_has_next = 1'b1;
                                    occ_next     = occ_reg + OCW'(1);
                                end
                            end
                        end
                        CMD_DONE_TAKEN: begin
                            if (occ_reg != '0) begin
                                occ_next = occ_reg - OCW'(1);
                            end else begin
                                out_status_next = ST_WRONG_STATE;
                            end
                        end
                        CMD_ABORT: begin
                            if (next_addr_reg == 32'd0 && cur_addr_reg == 32'd0 &&
                                count_reg == '0) begin
                                running_next = 1'b0;
                            end else begin
                                out_valid_next = out_valid_reg && !out_ready;
                                state_next     = S_AB_NEXT;
                            end
                        end
                        default: begin
                            out_status_next = ST_WRONG_STATE;
                        end
                    endcase
                end
            end

            S_AB_NEXT: begin
                if (next_addr_reg == 32'd0) begin
                    state_next = S_AB_CUR;
                end else if (can_emit) begin
                    rep_last       = (cur_addr_reg == 32'd0) && (count_reg == '0);
                    next_addr_next = 32'd0;
                    out_valid_next = 1'b1;
                    out_addr_next  = next_addr_reg;
                    out_ok_next    = 1'b0;
                    out_seq_next   = frame_cnt_reg;
                    out_last_next  = rep_last;
                    if (done_full) begin
                        out_status_next = ST_DROPPED;
                        out_has_next    = 1'b0;
                    end else begin
                        out_status_next = ST_OK;
                        out_has_next    = 1'b1;
                        occ_next        = occ_reg + OCW'(1);
                    end
                    if (rep_last) begin
                        running_next = 1'b0;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_AB_CUR;
                    end
                end
            end

            S_AB_CUR: begin
                if (cur_addr_reg == 32'd0) begin
                    if (count_reg == '0) begin
                        running_next = 1'b0;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_AB_PEND;
                    end
                end else if (can_emit) begin
                    rep_last       = (count_reg == '0);
                    cur_addr_next  = 32'd0;
                    out_valid_next = 1'b1;
                    out_addr_next  = cur_addr_reg;
                    out_ok_next    = 1'b0;
                    out_seq_next   = frame_cnt_reg;
                    out_last_next  = rep_last;
                    if (done_full) begin
                        out_status_next = ST_DROPPED;
                        out_has_next    = 1'b0;
                    end else begin
                        out_status_next = ST_OK;
                        out_has_next    = 1'b1;
                        occ_next        = occ_reg + OCW'(1);
                    end
                    if (rep_last) begin
                        running_next = 1'b0;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_AB_PEND;
                    end
                end
            end

            S_AB_PEND: begin
                if (can_emit) begin
                    // a drop stops the drain, the rest stay queued
                    rep_last       = done_full || (count_reg == PCW'(1));
                    head_next      = head_inc;
                    count_next     = count_reg - PCW'(1);
                    out_valid_next = 1'b1;
                    out_addr_next  = rd_data_reg;
                    out_ok_next    = 1'b0;
                    out_seq_next   = frame_cnt_reg;
                    out_last_next  = rep_last;
                    if (done_full) begin
                        out_status_next = ST_DROPPED;
                        out_has_next    = 1'b0;
                    end else begin
                        out_status_next = ST_OK;
                        out_has_next    = 1'b1;
                        occ_next        = occ_reg + OCW'(1);
                    end
                    if (rep_last) begin
                        running_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // pending FIFO store; read data always shows the entry at the head
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pend_mem[tail_reg] <= cmd_data.addr;
        end
        if (wr_en && (tail_reg == head_next)) begin
            rd_data_reg <= cmd_data.addr;
        end else begin
            rd_data_reg <= pend_mem[head_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            next_addr_reg <= 32'd0;
            cur_addr_reg  <= 32'd0;
            frame_cnt_reg <= 32'd0;
            occ_reg       <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            next_addr_reg <= next_addr_next;
            cur_addr_reg  <= cur_addr_next;
            frame_cnt_reg <= frame_cnt_next;
            occ_reg       <= occ_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
        out_status_reg <= out_status_next;
        out_has_reg    <= out_has_next;
        out_addr_reg   <= out_addr_next;
        out_ok_reg     <= out_ok_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_has_done = out_has_reg;
    assign out_addr     = out_addr_reg;
    assign out_ok       = out_ok_reg;
    assign out_seq      = out_seq_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

[rtl/frame_buffer_queue_manager_unit.sv]
// Path: a word waits in the two-word front queue and its result is registered onto m_.
// Throughput: one command per cycle while the result register can take a word; an abort
// with buffers held returns the armed slot, the current slot, then pending entries in turn.
// Rate is set by the single execution state machine and its one-word result register.
// Reset: aresetn is synchronous, active low; it empties the queues, clears both slots,
// the counters and the running flag. Pending store contents are not cleared.
`default_nettype none

module frame_buffer_queue_manager_unit
    import fbqm_pkg::*;
#(
    parameter int PENDING_DEPTH = 16,   // pending address FIFO depth
    parameter int DONE_DEPTH    = 32    // room in the downstream done queue
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // command words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] buffer_addr
    input  wire logic [2:0]  s_tuser,   // [2:0] command

    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [0] has_done, [32:1] done_addr, [33] done_ok,
                                        // [65:34] done_seq, [71:66] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast    // final result of a command
);

    fbqm_cmd_t   cmd_data;
    logic        cmd_valid;
    logic        cmd_ready;
    status_t     res_status;
    logic        res_has_done;
    logic [31:0] res_addr;
    logic        res_ok;
    logic [31:0] res_seq;

    // front end: decode and a two-word command queue
    fbqm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    // back end: buffer bookkeeping, abort drain, result register
    fbqm_back #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .DONE_DEPTH    (DONE_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_data     (cmd_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (res_status),
        .out_has_done (res_has_done),
        .out_addr     (res_addr),
        .out_ok       (res_ok),
        .out_seq      (res_seq),
        .out_last     (m_tlast)
    );

    assign m_tuser = res_status;
    assign m_tdata = {6'd0, res_seq, res_ok, res_addr, res_has_done};

endmodule

`default_nettype wire

[sim/tb_frame_buffer_queue_manager_unit.sv]
`default_nettype none

module tb_frame_buffer_queue_manager_unit;
    import fbqm_pkg::*;

    localparam int PENDING_DEPTH = 16;
    localparam int DONE_DEPTH    = 32;

    // the two command codes the block has no use for
    localparam logic [2:0] CODE_UNUSED_A = 3'd6;
    localparam logic [2:0] CODE_UNUSED_B = 3'd7;

    // cycles with no word moving on either side before the run is called dead
    localparam int STALL_LIMIT = 2000;
    // settling time after the last expected word
    localparam int DRAIN_CYCLES = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] buffer_addr
    logic [2:0]  s_tuser  = '0;     // [2:0] command
    wire logic        m_tvalid;
    logic             m_tready = 1'b0;
    wire logic [71:0] m_tdata;      // [0] has_done, [32:1] done_addr, [33] done_ok,
                                    // [65:34] done_seq, [71:66] zero
    wire logic [1:0]  m_tuser;      // [1:0] status
    wire logic        m_tlast;

    frame_buffer_queue_manager_unit #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .DONE_DEPTH    (DONE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predicted result words, oldest first
    // ------------------------------------------------------------------
    typedef struct {
        status_t     status;
        logic        has_done;
        logic [31:0] addr;
        logic        ok;
        logic [31:0] seq;
        logic        last;
    } done_word_t;

    done_word_t done_words_due[$];
    int         mismatch_count = 0;

    // the last word of a command is held back until the command is finished,
    // so that its last flag can be set before it is queued
    done_word_t held_word;
    logic       held_valid = 1'b0;

    // shadow of the block's state, at its own widths
    logic [31:0] pend_store [PENDING_DEPTH];
    logic [3:0]  pend_head  = '0;
    logic [4:0]  pend_count = '0;
    logic [31:0] armed_addr = '0;   // next-frame slot
    logic [31:0] active_addr = '0;  // current-frame slot
    logic [31:0] frame_seq  = '0;
    logic [5:0]  done_fill  = '0;   // occupied places in the consumer queue
    logic        run_flag   = 1'b0;

    // idling controls, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    function automatic void hold_word(input status_t st, input logic has,
                                      input logic [31:0] addr, input logic ok,
                                      input logic [31:0] seq);
        if (held_valid)
            done_words_due.push_back(held_word);
        held_word.status   = st;
        held_word.has_done = has;
        held_word.addr     = addr;
        held_word.ok       = ok;
        held_word.seq      = seq;
        held_word.last     = 1'b0;
        held_valid         = 1'b1;
    endfunction

    function automatic logic [31:0] pop_pending();
        logic [31:0] a;
        a          = pend_store[pend_head];
        pend_head  = pend_head + 4'd1;
        pend_count = pend_count - 5'd1;
        return a;
    endfunction

    // hand one buffer to the consumer queue; a full queue drops it but the
    // word still carries its address, ok flag and sequence number
    function automatic logic report_buffer(input logic [31:0] addr, input logic ok);
        if (int'(done_fill) >= DONE_DEPTH) begin
            hold_word(ST_DROPPED, 1'b0, addr, ok, frame_seq);
            return 1'b1;
        end
        done_fill = done_fill + 6'd1;
        hold_word(ST_OK, 1'b1, addr, ok, frame_seq);
        return 1'b0;
    endfunction

    // advance the shadow state by one command and queue the words it causes
    function automatic void queue_manager_step(input logic [2:0] cmd,
                                               input logic [31:0] addr);
        status_t    st;
        logic       dropped;
        logic [3:0] slot;
        case (cmd)
            CODE_START: begin
                if (run_flag) begin
                    hold_word(ST_WRONG_STATE, 1'b0, '0, 1'b0, '0);
                end else begin
                    active_addr = '0;
                    armed_addr  = '0;
                    run_flag    = 1'b1;
                    hold_word(ST_OK, 1'b0, '0, 1'b0, '0);
                end
            end
            CODE_ADD_BUFFER: begin
                st = ST_OK;
                if (!run_flag) begin
                    st = ST_WRONG_STATE;
                end else if (DONE_DEPTH - int'(done_fill) < int'(pend_count) + 1 ||
                             int'(pend_count) >= PENDING_DEPTH) begin
                    st = ST_NO_ROOM;
                end else begin
                    slot             = pend_head + pend_count[3:0];
                    pend_store[slot] = addr;
                    pend_count       = pend_count + 5'd1;
                end
                // while running, arming ignores the status; an armed zero is lost later
                if (run_flag && armed_addr == '0 && pend_count != '0)
                    armed_addr = pop_pending();
                hold_word(st, 1'b0, '0, 1'b0, '0);
            end
            CODE_FRAME_START: begin
                if (!run_flag) begin
                    hold_word(ST_WRONG_STATE, 1'b0, '0, 1'b0, '0);
                end else begin
                    frame_seq = frame_seq + 32'd1;
                    // an unfinished current frame is overwritten
                    if (armed_addr != '0)
                        active_addr = armed_addr;
                    if (pend_count != '0)
                        armed_addr = pop_pending();
                    else
                        armed_addr = '0;
                    hold_word(ST_OK, 1'b0, '0, 1'b0, '0);
                end
            end
            CODE_FRAME_END: begin
                if (!run_flag) begin
                    hold_word(ST_WRONG_STATE, 1'b0, '0, 1'b0, '0);
                end else if (active_addr != '0) begin
                    dropped     = report_buffer(active_addr, 1'b1);
                    active_addr = '0;
                end else begin
                    hold_word(ST_OK, 1'b0, '0, 1'b0, '0);
                end
            end
            CODE_DONE_TAKEN: begin
                if (done_fill != '0) begin
                    done_fill = done_fill - 6'd1;
                    hold_word(ST_OK, 1'b0, '0, 1'b0, '0);
                end else begin
                    hold_word(ST_WRONG_STATE, 1'b0, '0, 1'b0, '0);
                end
            end
            CODE_ABORT: begin
                // armed slot, then current slot, then pending entries in order;
                // a drop on a pending entry leaves the rest queued
                if (armed_addr != '0)
                    dropped = report_buffer(armed_addr, 1'b0);
                if (active_addr != '0)
                    dropped = report_buffer(active_addr, 1'b0);
                armed_addr  = '0;
                active_addr = '0;
                dropped     = 1'b0;
                while (pend_count != '0 && !dropped)
                    dropped = report_buffer(pop_pending(), 1'b0);
                run_flag = 1'b0;
                if (!held_valid)
                    hold_word(ST_OK, 1'b0, '0, 1'b0, '0);
            end
            default: begin
                hold_word(ST_WRONG_STATE, 1'b0, '0, 1'b0, '0);
            end
        endcase
        held_word.last = 1'b1;
        done_words_due.push_back(held_word);
        held_valid = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one command word, with a random gap in front of it
    // ------------------------------------------------------------------
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] addr);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        queue_manager_step(cmd, addr);
    endtask

    // receiver back-pressure, redrawn each cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        done_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (done_words_due.size() == 0) begin
                $error("result word with nothing expected: status %0d addr %0h",
                       m_tuser, m_tdata[32:1]);
                mismatch_count++;
            end else begin
                want = done_words_due.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[0] !== want.has_done) begin
                    $error("has_done: expected %0d, got %0d", want.has_done, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[32:1] !== want.addr) begin
                    $error("done_addr: expected %0h, got %0h", want.addr, m_tdata[32:1]);
                    mismatch_count++;
                end
                if (m_tdata[33] !== want.ok) begin
                    $error("done_ok: expected %0d, got %0d", want.ok, m_tdata[33]);
                    mismatch_count++;
                end
                if (m_tdata[65:34] !== want.seq) begin
                    $error("done_seq: expected %0d, got %0d", want.seq, m_tdata[65:34]);
                    mismatch_count++;
                end
                if (m_tdata[71:66] !== 6'd0) begin
                    $error("padding: expected 0, got %0h", m_tdata[71:66]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which no word moves on either side
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("frame_buffer_queue_manager_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_buffer_addr();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // profile 0 balanced, 1 heavy on adds (fills the pending queue),
    // 2 never takes done words (fills the consumer queue)
    function automatic logic [2:0] pick_command(input int profile);
        int r;
        r = $urandom_range(99);
        case (profile)
            0: begin
                if (r < 30) return CODE_ADD_BUFFER;
                if (r < 50) return CODE_FRAME_START;
                if (r < 70) return CODE_FRAME_END;
                if (r < 85) return CODE_DONE_TAKEN;
                if (r < 90) return CODE_ABORT;
                if (r < 95) return CODE_START;
            end
            1: begin
                if (r < 65) return CODE_ADD_BUFFER;
                if (r < 75) return CODE_FRAME_START;
                if (r < 85) return CODE_FRAME_END;
                if (r < 90) return CODE_DONE_TAKEN;
                if (r < 92) return CODE_ABORT;
                if (r < 95) return CODE_START;
            end
            default: begin
                if (r < 35) return CODE_ADD_BUFFER;
                if (r < 60) return CODE_FRAME_START;
                if (r < 90) return CODE_FRAME_END;
                if (r < 92) return CODE_ABORT;
                if (r < 96) return CODE_START;
            end
        endcase
        return ($urandom_range(1) != 0) ? CODE_UNUSED_B : CODE_UNUSED_A;
    endfunction

    // add, frame start/end and unused codes are refused while stopped; abort is accepted
    task automatic test_stopped_commands();
        send_word(CODE_ADD_BUFFER, 32'h0000_1234);
        send_word(CODE_FRAME_START, 32'hFFFF_FFFF);
        send_word(CODE_FRAME_END, '0);
        send_word(CODE_DONE_TAKEN, '0);
        send_word(CODE_ABORT, '0);
        send_word(CODE_UNUSED_A, 32'hA5A5_A5A5);
        send_word(CODE_UNUSED_B, 32'h5A5A_5A5A);
    endtask

    // start twice, a zero address consumed on arming, frame overwrite,
    // empty frame end, done taken down past zero, abort with both slots held
    task automatic test_frame_flow();
        send_word(CODE_START, '0);
        send_word(CODE_START, '0);
        send_word(CODE_ADD_BUFFER, 32'h0000_0000);
        send_word(CODE_ADD_BUFFER, 32'hFFFF_FFFF);
        send_word(CODE_ADD_BUFFER, 32'h0000_0001);
        send_word(CODE_ADD_BUFFER, 32'h8000_0000);
        send_word(CODE_FRAME_START, '0);
        send_word(CODE_FRAME_END, '0);
        send_word(CODE_FRAME_END, '0);
        send_word(CODE_FRAME_START, '0);
        send_word(CODE_FRAME_START, '0);
        send_word(CODE_DONE_TAKEN, '0);
        send_word(CODE_DONE_TAKEN, '0);
        send_word(CODE_ADD_BUFFER, 32'h0000_0005);
        send_word(CODE_ADD_BUFFER, 32'h7FFF_FFFE);
        send_word(CODE_FRAME_START, '0);
        send_word(CODE_ABORT, '0);
    endtask

    // sessions of random traffic with some unused codes, mostly opened by start and
    // closed by abort; the odd session leaves the block running or stopped at random
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int word_budget);
        int sent;
        int profile;
        int session_len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < word_budget) begin
            profile = $urandom_range(2);
            if ($urandom_range(9) != 0) begin
                send_word(CODE_START, $urandom);
                sent++;
            end
            session_len = $urandom_range(40, 8);
            repeat (session_len) begin
                send_word(pick_command(profile), random_buffer_addr());
                sent++;
            end
            if ($urandom_range(4) != 0) begin
                send_word(CODE_ABORT, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_stopped_commands();
        test_frame_flow();
        test_random_traffic(0, 0, 40);     // no idling
        test_random_traffic(70, 0, 35);    // sender mostly idle
        test_random_traffic(0, 70, 35);    // receiver mostly stalling
        test_random_traffic(20, 20, 40);   // both

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (done_words_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && done_words_due.size() == 0) begin
            $display("frame_buffer_queue_manager_unit: match");
        end else begin
            $display("frame_buffer_queue_manager_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/fbqm_pkg.sv
rtl/fbqm_front.sv
rtl/fbqm_back.sv
rtl/frame_buffer_queue_manager_unit.sv
sim/tb_frame_buffer_queue_manager_unit.sv
